FILE: design/qrcm_pkg.sv
package qrcm_pkg;

  // Field and coordinate widths
  localparam int DataW  = 10;
  localparam int CoordW = 11;
  localparam int WordW  = 32;

  // Parameter defaults
  localparam int GridSizeDef  = 512;
  localparam int NodeCountDef = 349525;

  // Command codes
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_COVER = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  // Register indexes
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_C_CHK,
    ST_C_EVAL,
    ST_C_ADV,
    ST_Q_CHK,
    ST_Q_EVAL
  } state_e;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLR,
    OP_READ,
    OP_SET,
    OP_PUSH,
    OP_NEXT,
    OP_POP,
    OP_DESC,
    OP_EMIT0,
    OP_EMIT1
  } op_e;

  // Node span: rows i..k, columns j..l
  typedef struct packed {
    logic [CoordW-1:0] i;
    logic [CoordW-1:0] j;
    logic [CoordW-1:0] k;
    logic [CoordW-1:0] l;
  } frame_t;

  // Datapath status toward the controller
  typedef struct packed {
    logic meets;
    logic enclosed;
    logic oob;
    logic flag;
    logic cell_in;
    logic leaf;
    logic lvl_zero;
    logic last_child;
    logic clr_last;
  } status_t;

  // Number of tree levels needed to hold nc nodes
  function automatic int tree_levels(int nc);
    int tot;
    int pw;
    int lv;
    tot = 0;
    pw  = 1;
    lv  = 0;
    for (int s = 0; s < 32; s++) begin
      if (tot < nc) begin
        tot = tot + pw;
        pw  = pw * 4;
        lv  = lv + 1;
      end
    end
    return lv;
  endfunction

  // Span of child c (bit0: lower rows, bit1: right columns)
  function automatic frame_t child_frame(frame_t p, logic [1:0] c);
    logic [CoordW:0]   rs;
    logic [CoordW:0]   cs;
    logic [CoordW-1:0] mr;
    logic [CoordW-1:0] mc;
    frame_t            f;
    rs = {1'b0, p.i} + {1'b0, p.k};
    cs = {1'b0, p.j} + {1'b0, p.l};
    mr = rs[CoordW:1];
    mc = cs[CoordW:1];
    f  = p;
    if (c[0]) f.i = mr + 1'b1;
    else      f.k = mr;
    if (c[1]) f.j = mc + 1'b1;
    else      f.l = mc;
    return f;
  endfunction

endpackage

FILE: design/quadtree_rect_cover_map.sv
// Quadtree cover map: clear, cover rectangle, query cell; one command at a time.
// Query: a flag read and an evaluate step per tree level; the result strobe
// is registered from the emitting step. Cover: at most a check, an evaluate
// and an advance step per visited node, plus an advance step per stack pop.
// Clear and reset: one 32-bit flag word per cycle, ceil(NODE_COUNT/32) words
// (10923 by default), busy throughout; no stalls.
module quadtree_rect_cover_map #(
  parameter int GRID_SIZE  = qrcm_pkg::GridSizeDef,
  parameter int NODE_COUNT = qrcm_pkg::NodeCountDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  command_i,
  input  logic [qrcm_pkg::DataW-1:0]  row_first_i,
  input  logic [qrcm_pkg::DataW-1:0]  col_first_i,
  input  logic [qrcm_pkg::DataW-1:0]  row_last_i,
  input  logic [qrcm_pkg::DataW-1:0]  col_last_i,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [qrcm_pkg::DataW-1:0]  cfg_data_i,
  output logic                        covered_o,
  output logic                        result_valid_o
);

  qrcm_pkg::op_e     op;
  qrcm_pkg::status_t status;

  qrcm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (command_i),
    .status_i  (status),
    .op_o      (op),
    .busy      (busy)
  );

  qrcm_dpath #(
    .GRID_SIZE  (GRID_SIZE),
    .NODE_COUNT (NODE_COUNT)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .row_first_i    (row_first_i),
    .col_first_i    (col_first_i),
    .row_last_i     (row_last_i),
    .col_last_i     (col_last_i),
    .status_o       (status),
    .covered_o      (covered_o),
    .result_valid_o (result_valid_o)
  );

endmodule

FILE: design/qrcm_ctrl.sv
module qrcm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic [1:0]         command_i,
  input  qrcm_pkg::status_t  status_i,
  output qrcm_pkg::op_e      op_o,
  output logic               busy
);

  qrcm_pkg::state_e state_q, state_d;

  // State register; reset enters the clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qrcm_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      qrcm_pkg::ST_IDLE: begin
        if (start) begin
          if (command_i == qrcm_pkg::CMD_CLEAR)      state_d = qrcm_pkg::ST_CLEAR;
          else if (command_i == qrcm_pkg::CMD_COVER) state_d = qrcm_pkg::ST_C_CHK;
          else if (command_i == qrcm_pkg::CMD_QUERY) state_d = qrcm_pkg::ST_Q_CHK;
        end
      end
      qrcm_pkg::ST_CLEAR: begin
        if (status_i.clr_last) state_d = qrcm_pkg::ST_IDLE;
      end
      qrcm_pkg::ST_C_CHK: begin
        if (!status_i.meets || status_i.oob) state_d = qrcm_pkg::ST_C_ADV;
        else                                 state_d = qrcm_pkg::ST_C_EVAL;
      end
      qrcm_pkg::ST_C_EVAL: begin
        if (status_i.flag || status_i.enclosed) state_d = qrcm_pkg::ST_C_ADV;
        else                                    state_d = qrcm_pkg::ST_C_CHK;
      end
      qrcm_pkg::ST_C_ADV: begin
        if (status_i.lvl_zero)         state_d = qrcm_pkg::ST_IDLE;
        else if (!status_i.last_child) state_d = qrcm_pkg::ST_C_CHK;
      end
      qrcm_pkg::ST_Q_CHK: begin
        if (!status_i.cell_in || status_i.oob) state_d = qrcm_pkg::ST_IDLE;
        else                                   state_d = qrcm_pkg::ST_Q_EVAL;
      end
      qrcm_pkg::ST_Q_EVAL: begin
        if (status_i.flag || status_i.leaf) state_d = qrcm_pkg::ST_IDLE;
        else                                state_d = qrcm_pkg::ST_Q_CHK;
      end
      default: state_d = qrcm_pkg::ST_IDLE;
    endcase
  end

  // Operation to the datapath
  always_comb begin
    op_o = qrcm_pkg::OP_NONE;
    busy = 1'b1;
    unique case (state_q)
      qrcm_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start && (command_i == qrcm_pkg::CMD_COVER ||
                      command_i == qrcm_pkg::CMD_QUERY)) begin
          op_o = qrcm_pkg::OP_LOAD;
        end
      end
      qrcm_pkg::ST_CLEAR: op_o = qrcm_pkg::OP_CLR;
      qrcm_pkg::ST_C_CHK: begin
        if (status_i.meets && !status_i.oob) op_o = qrcm_pkg::OP_READ;
      end
      qrcm_pkg::ST_C_EVAL: begin
        priority if (status_i.flag)  op_o = qrcm_pkg::OP_NONE;
        else if (status_i.enclosed)  op_o = qrcm_pkg::OP_SET;
        else                         op_o = qrcm_pkg::OP_PUSH;
      end
      qrcm_pkg::ST_C_ADV: begin
        priority if (status_i.lvl_zero) op_o = qrcm_pkg::OP_NONE;
        else if (status_i.last_child)   op_o = qrcm_pkg::OP_POP;
        else                            op_o = qrcm_pkg::OP_NEXT;
      end
      qrcm_pkg::ST_Q_CHK: begin
        if (!status_i.cell_in || status_i.oob) op_o = qrcm_pkg::OP_EMIT0;
        else                                   op_o = qrcm_pkg::OP_READ;
      end
      qrcm_pkg::ST_Q_EVAL: begin
        priority if (status_i.flag) op_o = qrcm_pkg::OP_EMIT1;
        else if (status_i.leaf)     op_o = qrcm_pkg::OP_EMIT0;
        else                        op_o = qrcm_pkg::OP_DESC;
      end
      default: op_o = qrcm_pkg::OP_NONE;
    endcase
  end

endmodule

FILE: design/qrcm_dpath.sv
module qrcm_dpath #(
  parameter int GRID_SIZE  = qrcm_pkg::GridSizeDef,
  parameter int NODE_COUNT = qrcm_pkg::NodeCountDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  qrcm_pkg::op_e               op_i,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [qrcm_pkg::DataW-1:0]  cfg_data_i,
  input  logic [qrcm_pkg::DataW-1:0]  row_first_i,
  input  logic [qrcm_pkg::DataW-1:0]  col_first_i,
  input  logic [qrcm_pkg::DataW-1:0]  row_last_i,
  input  logic [qrcm_pkg::DataW-1:0]  col_last_i,
  output qrcm_pkg::status_t           status_o,
  output logic                        covered_o,
  output logic                        result_valid_o
);

  localparam int CW     = qrcm_pkg::CoordW;
  localparam int NodeW  = $clog2(4 * NODE_COUNT + 1);
  localparam int Depth  = qrcm_pkg::tree_levels(NODE_COUNT);
  localparam int IdxW   = $clog2(Depth);
  localparam int LvlW   = $clog2(Depth + 1);
  localparam int Words  = (NODE_COUNT + qrcm_pkg::WordW - 1) / qrcm_pkg::WordW;
  localparam int WordAw = (Words > 1) ? $clog2(Words) : 1;
  localparam int BitW   = $clog2(qrcm_pkg::WordW);

  // Grid size registers
  logic [CW-1:0] rows_q, cols_q;
  logic [CW-1:0] cfg_v;

  always_comb begin
    cfg_v = {1'b0, cfg_data_i};
    if (cfg_v == '0) cfg_v = CW'(1);
    else if (cfg_v > CW'(GRID_SIZE)) cfg_v = CW'(GRID_SIZE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= CW'(GRID_SIZE);
      cols_q <= CW'(GRID_SIZE);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == qrcm_pkg::REG_ROWS) rows_q <= cfg_v;
      if (cfg_idx_i == qrcm_pkg::REG_COLS) cols_q <= cfg_v;
    end
  end

  // Walk state: current node, rectangle or cell, frame stack
  qrcm_pkg::frame_t cur_q;
  logic [NodeW-1:0] node_q;
  logic [CW-1:0]    ra_q, rb_q, rc_q, rd_q;
  logic [LvlW-1:0]  lvl_q;
  qrcm_pkg::frame_t stk_f_q [Depth];
  logic [NodeW-1:0] stk_n_q [Depth];
  logic [1:0]       stk_c_q [Depth];
  logic [WordAw-1:0] clr_q;
  logic             vld_q, cov_q;

  logic [IdxW-1:0]  push_idx, par_idx;
  logic [1:0]       nxt_c, desc_c;
  logic [CW-1:0]    mr, mc;
  logic [CW:0]      rsum, csum;

  assign push_idx = lvl_q[IdxW-1:0];
  assign par_idx  = IdxW'(lvl_q - 1'b1);
  assign nxt_c    = stk_c_q[par_idx] + 2'd1;
  assign rsum     = {1'b0, cur_q.i} + {1'b0, cur_q.k};
  assign csum     = {1'b0, cur_q.j} + {1'b0, cur_q.l};
  assign mr       = rsum[CW:1];
  assign mc       = csum[CW:1];
  assign desc_c   = {(rb_q > mc), (ra_q > mr)};

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q <= '0;
      clr_q <= '0;
      vld_q <= 1'b0;
    end else begin
      vld_q <= (op_i == qrcm_pkg::OP_EMIT0) || (op_i == qrcm_pkg::OP_EMIT1);
      unique case (op_i)
        qrcm_pkg::OP_LOAD: lvl_q <= '0;
        qrcm_pkg::OP_PUSH: lvl_q <= lvl_q + 1'b1;
        qrcm_pkg::OP_POP:  lvl_q <= lvl_q - 1'b1;
        qrcm_pkg::OP_CLR:  clr_q <= status_o.clr_last ? '0 : clr_q + 1'b1;
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (op_i == qrcm_pkg::OP_EMIT1) cov_q <= 1'b1;
    else if (op_i == qrcm_pkg::OP_EMIT0) cov_q <= 1'b0;
    unique case (op_i)
      qrcm_pkg::OP_LOAD: begin
        cur_q  <= '{i: CW'(1), j: CW'(1), k: rows_q, l: cols_q};
        node_q <= '0;
        ra_q   <= {1'b0, row_first_i};
        rb_q   <= {1'b0, col_first_i};
        rc_q   <= {1'b0, row_last_i};
        rd_q   <= {1'b0, col_last_i};
      end
      qrcm_pkg::OP_PUSH: begin
        stk_f_q[push_idx] <= cur_q;
        stk_n_q[push_idx] <= node_q;
        stk_c_q[push_idx] <= 2'd0;
        cur_q  <= qrcm_pkg::child_frame(cur_q, 2'd0);
        node_q <= {node_q[NodeW-3:0], 2'b00} + NodeW'(1);
      end
      qrcm_pkg::OP_NEXT: begin
        stk_c_q[par_idx] <= nxt_c;
        cur_q  <= qrcm_pkg::child_frame(stk_f_q[par_idx], nxt_c);
        node_q <= {stk_n_q[par_idx][NodeW-3:0], 2'b00} + NodeW'(nxt_c) + NodeW'(1);
      end
      qrcm_pkg::OP_DESC: begin
        cur_q  <= qrcm_pkg::child_frame(cur_q, desc_c);
        node_q <= {node_q[NodeW-3:0], 2'b00} + NodeW'(desc_c) + NodeW'(1);
      end
      default: ;
    endcase
  end

  // Flag memory, one word per 32 nodes, registered read
  logic [qrcm_pkg::WordW-1:0] mem [Words];
  logic [qrcm_pkg::WordW-1:0] rdata_q;
  logic [WordAw-1:0]          node_word;
  logic [BitW-1:0]            node_bit;

  assign node_word = WordAw'(node_q >> BitW);
  assign node_bit  = node_q[BitW-1:0];

  always_ff @(posedge clk_i) begin
    if (op_i == qrcm_pkg::OP_CLR) begin
      mem[clr_q] <= '0;
    end else if (op_i == qrcm_pkg::OP_SET) begin
      mem[node_word] <= rdata_q | (qrcm_pkg::WordW'(1) << node_bit);
    end
    if (op_i == qrcm_pkg::OP_READ) rdata_q <= mem[node_word];
  end

  // Status
  logic [CW-1:0] top, left, bottom, right;
  always_comb begin
    top    = (cur_q.i > ra_q) ? cur_q.i : ra_q;
    left   = (cur_q.j > rb_q) ? cur_q.j : rb_q;
    bottom = (cur_q.k < rc_q) ? cur_q.k : rc_q;
    right  = (cur_q.l < rd_q) ? cur_q.l : rd_q;
    status_o.meets    = (top <= bottom) && (left <= right);
    status_o.enclosed = (ra_q <= cur_q.i) && (cur_q.k <= rc_q) &&
                        (rb_q <= cur_q.j) && (cur_q.l <= rd_q);
    status_o.oob      = node_q >= NodeW'(NODE_COUNT);
    status_o.flag     = rdata_q[node_bit];
    status_o.cell_in  = (cur_q.i <= ra_q) && (ra_q <= cur_q.k) &&
                        (cur_q.j <= rb_q) && (rb_q <= cur_q.l);
    status_o.leaf     = (cur_q.i == cur_q.k) && (cur_q.j == cur_q.l);
    status_o.lvl_zero   = lvl_q == '0;
    status_o.last_child = stk_c_q[par_idx] == 2'd3;
    status_o.clr_last   = clr_q == WordAw'(Words - 1);
  end

  assign covered_o      = cov_q;
  assign result_valid_o = vld_q;

endmodule

FILE: design/qrcm_checker.sv
module qrcm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic [1:0] command_i,
  input logic       result_valid_o
);

  // A result only shows once the walk has ended
  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy) else $error("result while busy");

  // Results are never back to back
  a_res_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("back to back results");

  // A valid command taken while idle always makes the block busy
  a_cmd_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (command_i == qrcm_pkg::CMD_CLEAR ||
     command_i == qrcm_pkg::CMD_COVER || command_i == qrcm_pkg::CMD_QUERY))
    |=> busy) else $error("command not taken");

  // No result appears out of an idle cycle without a transfer
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && !start) |=> !result_valid_o) else $error("spurious result");

endmodule

bind quadtree_rect_cover_map qrcm_checker u_qrcm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .command_i      (command_i),
  .result_valid_o (result_valid_o)
);
